### rtl/rrd_pkg.sv
// Package for the replay record deframer.
// Types, codes and constants shared by the parser, the word emitter and the checker.
// No dependencies.
package rrd_pkg;

    localparam int MAX_PLAYERS_DEF = 4;

    localparam logic [8:0]  HDR_SHORT   = 9'd272;
    localparam logic [8:0]  HDR_LONG    = 9'd400;
    localparam logic [8:0]  CNT_POS     = 9'd268;
    localparam logic [31:0] MAGIC_SHORT = 32'h3043524B;
    localparam logic [31:0] MAGIC_LONG  = 32'h3143524B;

    localparam logic [7:0] TYPE_DATA  = 8'h12;
    localparam logic [7:0] TYPE_TEXT  = 8'h14;
    localparam logic [7:0] TYPE_PAIR  = 8'h08;

    localparam logic [2:0] SKIP_LEN   = 3'd4;

    localparam logic [1:0] KIND_REC   = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_SUM   = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_HDR     = 3'd3;
    localparam logic [2:0] ST_NOFRAME = 3'd4;

    localparam int TDATA_W = 96;

    typedef enum logic [1:0] {
        FMT_UNKNOWN,
        FMT_SHORT,
        FMT_LONG,
        FMT_BAD
    } t_fmt;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_TXT14,
        PH_SKIP4,
        PH_TXT08A,
        PH_TXT08B,
        PH_STOP
    } t_phase;

    // Results caused by one input word, minus the filler count.
    typedef struct packed {
        logic        data_en;
        logic [7:0]  data;
        logic        sum_en;
        logic [31:0] frames;
        logic [31:0] delays;
        logic [2:0]  status;
        logic [15:0] cut;
    } t_job;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/rrd_parse.sv
// Header and record parser for the replay record deframer.
// Holds the file state; turns each accepted input word into a result job.
// Depends on rrd_pkg.
module rrd_parse #(
    parameter int MAX_PLAYERS = rrd_pkg::MAX_PLAYERS_DEF,
    parameter int PW          = $clog2(MAX_PLAYERS + 1),
    parameter int FW          = PW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output rrd_pkg::t_job        o_job,
    output logic [FW-1:0]        o_fill
);

    logic [8:0]      r_hdr_pos,  n_hdr_pos;
    rrd_pkg::t_fmt   r_fmt,      n_fmt;
    logic [31:0]     r_magic,    n_magic;
    logic [31:0]     r_cnt,      n_cnt;
    logic [PW-1:0]   r_players,  n_players;
    rrd_pkg::t_phase r_phase,    n_phase;
    logic [15:0]     r_rem,      n_rem;
    logic [15:0]     r_done,     n_done;
    logic [31:0]     r_frames,   n_frames;
    logic [31:0]     r_delays,   n_delays;
    logic            r_in_delay, n_in_delay;
    logic [2:0]      r_skip,     n_skip;

    logic [15:0]     len;
    logic            len_zero;

    assign len      = {i_byte, r_rem[7:0]};
    assign len_zero = (len == 16'd0);

    // next state
    always_comb begin
        n_hdr_pos  = (r_hdr_pos < rrd_pkg::HDR_LONG) ? r_hdr_pos + 9'd1 : r_hdr_pos;
        n_fmt      = r_fmt;
        n_magic    = r_magic;
        n_cnt      = r_cnt;
        n_players  = r_players;
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_done     = r_done;
        n_frames   = r_frames;
        n_delays   = r_delays;
        n_in_delay = r_in_delay;
        n_skip     = r_skip;
        unique case (r_phase)
            rrd_pkg::PH_HEADER: begin
                if (r_hdr_pos < 9'd4) begin
                    n_magic = {i_byte, r_magic[31:8]};
                end
                if (r_hdr_pos == 9'd3) begin
                    if (n_magic == rrd_pkg::MAGIC_SHORT) begin
                        n_fmt = rrd_pkg::FMT_SHORT;
                    end else if (n_magic == rrd_pkg::MAGIC_LONG) begin
                        n_fmt = rrd_pkg::FMT_LONG;
                    end else begin
                        n_fmt   = rrd_pkg::FMT_BAD;
                        n_phase = rrd_pkg::PH_STOP;
                    end
                end
                if (r_hdr_pos >= rrd_pkg::CNT_POS && r_hdr_pos < rrd_pkg::CNT_POS + 9'd4) begin
                    n_cnt = {i_byte, r_cnt[31:8]};
                end
                if (r_hdr_pos == rrd_pkg::CNT_POS + 9'd3) begin
                    if (n_cnt[31] || n_cnt == 32'd0) begin
                        n_players = PW'(1);
                    end else if (n_cnt > 32'(MAX_PLAYERS)) begin
                        n_players = PW'(MAX_PLAYERS);
                    end else begin
                        n_players = n_cnt[PW-1:0];
                    end
                end
                if ((r_fmt == rrd_pkg::FMT_SHORT && r_hdr_pos == rrd_pkg::HDR_SHORT - 9'd1) ||
                    (r_fmt == rrd_pkg::FMT_LONG  && r_hdr_pos == rrd_pkg::HDR_LONG - 9'd1)) begin
                    n_phase = rrd_pkg::PH_TYPE;
                end
            end
            rrd_pkg::PH_TYPE: begin
                if (!i_last) begin
                    if (i_byte == rrd_pkg::TYPE_DATA) begin
                        n_phase = rrd_pkg::PH_LEN_LO;
                    end else if (i_byte == rrd_pkg::TYPE_TEXT) begin
                        n_phase = rrd_pkg::PH_TXT14;
                    end else if (i_byte == rrd_pkg::TYPE_PAIR) begin
                        n_phase = rrd_pkg::PH_TXT08A;
                    end else begin
                        n_phase = rrd_pkg::PH_STOP;
                    end
                end
            end
            rrd_pkg::PH_LEN_LO: begin
                n_rem   = {8'd0, i_byte};
                n_phase = rrd_pkg::PH_LEN_HI;
            end
            rrd_pkg::PH_LEN_HI: begin
                n_rem = len;
                if (len_zero) begin
                    if (r_in_delay) begin
                        n_delays = rrd_pkg::sat_inc(r_delays);
                    end
                    n_frames = rrd_pkg::sat_inc(r_frames);
                    n_phase  = rrd_pkg::PH_TYPE;
                end else begin
                    n_in_delay = 1'b0;
                    n_done     = 16'd0;
                    n_phase    = rrd_pkg::PH_DATA;
                end
            end
            rrd_pkg::PH_DATA: begin
                n_done = r_done + 16'd1;
                n_rem  = r_rem - 16'd1;
                if (r_rem == 16'd1) begin
                    n_frames = rrd_pkg::sat_inc(r_frames);
                    n_phase  = rrd_pkg::PH_TYPE;
                end
            end
            rrd_pkg::PH_TXT14: begin
                if (i_byte == 8'd0) begin
                    n_skip  = rrd_pkg::SKIP_LEN;
                    n_phase = rrd_pkg::PH_SKIP4;
                end
            end
            rrd_pkg::PH_SKIP4: begin
                if (r_skip != 3'd0) begin
                    n_skip = r_skip - 3'd1;
                end
                if (n_skip == 3'd0) begin
                    n_phase = rrd_pkg::PH_TYPE;
                end
            end
            rrd_pkg::PH_TXT08A: begin
                if (i_byte == 8'd0) begin
                    n_phase = rrd_pkg::PH_TXT08B;
                end
            end
            rrd_pkg::PH_TXT08B: begin
                if (i_byte == 8'd0) begin
                    n_phase = rrd_pkg::PH_TYPE;
                end
            end
            default: begin
            end
        endcase
    end

    // job outputs
    always_comb begin
        o_job         = '0;
        o_fill        = '0;
        o_job.data_en = (r_phase == rrd_pkg::PH_DATA);
        o_job.data    = i_byte;
        if (r_phase == rrd_pkg::PH_LEN_HI && len_zero) begin
            o_fill = FW'({r_players, 2'b00});
        end
        o_job.sum_en = i_last;
        o_job.frames = n_frames;
        o_job.delays = n_delays;
        if (n_hdr_pos < rrd_pkg::HDR_SHORT) begin
            o_job.status = rrd_pkg::ST_SHORT;
        end else if (n_fmt != rrd_pkg::FMT_SHORT && n_fmt != rrd_pkg::FMT_LONG) begin
            o_job.status = rrd_pkg::ST_MAGIC;
        end else if (n_fmt == rrd_pkg::FMT_LONG && n_hdr_pos < rrd_pkg::HDR_LONG) begin
            o_job.status = rrd_pkg::ST_HDR;
        end else if (n_frames == 32'd0) begin
            o_job.status = rrd_pkg::ST_NOFRAME;
        end else begin
            o_job.status = rrd_pkg::ST_OK;
        end
        o_job.cut = (n_phase == rrd_pkg::PH_DATA) ? n_done : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_hdr_pos  <= 9'd0;
            r_fmt      <= rrd_pkg::FMT_UNKNOWN;
            r_magic    <= 32'd0;
            r_cnt      <= 32'd0;
            r_players  <= PW'(1);
            r_phase    <= rrd_pkg::PH_HEADER;
            r_rem      <= 16'd0;
            r_done     <= 16'd0;
            r_frames   <= 32'd0;
            r_delays   <= 32'd0;
            r_in_delay <= 1'b1;
            r_skip     <= 3'd0;
        end else if (i_accept) begin
            r_hdr_pos  <= n_hdr_pos;
            r_fmt      <= n_fmt;
            r_magic    <= n_magic;
            r_cnt      <= n_cnt;
            r_players  <= n_players;
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_done     <= n_done;
            r_frames   <= n_frames;
            r_delays   <= n_delays;
            r_in_delay <= n_in_delay;
            r_skip     <= n_skip;
        end
    end

endmodule

### rtl/rrd_emit.sv
// Result emitter for the replay record deframer.
// Holds one job and plays it out one word per unstalled cycle through an output register.
// Depends on rrd_pkg.
module rrd_emit #(
    parameter int FW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  rrd_pkg::t_job                 i_job,
    input  logic [FW-1:0]                 i_fill,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrd_pkg::TDATA_W-1:0]   m_tdata,  // out_byte, frame_total, delay_total,
                                                    // status, cut_bytes, pad
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser   // out_kind
);

    logic          r_data_en;
    logic [7:0]    r_data;
    logic [FW-1:0] r_fill;
    logic          r_sum_en;
    logic [31:0]   r_frames;
    logic [31:0]   r_delays;
    logic [2:0]    r_status;
    logic [15:0]   r_cut;

    logic          r_valid;
    logic [7:0]    r_o_byte;
    logic [1:0]    r_o_kind;
    logic          r_o_last;
    logic [31:0]   r_o_frames;
    logic [31:0]   r_o_delays;
    logic [2:0]    r_o_status;
    logic [15:0]   r_o_cut;

    logic [FW:0]   items;
    logic          out_move;
    logic          step;
    logic          take;

    assign items    = (FW+1)'(r_fill) + (FW+1)'(r_data_en) + (FW+1)'(r_sum_en);
    assign out_move = !r_valid || m_tready;
    assign step     = out_move && (items != '0);
    assign o_job_ready = (items == '0) || (items == (FW+1)'(1) && out_move);
    assign take     = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_en <= 1'b0;
            r_fill    <= '0;
            r_sum_en  <= 1'b0;
        end else if (take) begin
            r_data_en <= i_job.data_en;
            r_fill    <= i_fill;
            r_sum_en  <= i_job.sum_en;
        end else if (step) begin
            if (r_data_en) begin
                r_data_en <= 1'b0;
            end else if (r_fill != '0) begin
                r_fill <= r_fill - FW'(1);
            end else begin
                r_sum_en <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data   <= i_job.data;
            r_frames <= i_job.frames;
            r_delays <= i_job.delays;
            r_status <= i_job.status;
            r_cut    <= i_job.cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_move) begin
            r_valid <= (items != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_last   <= (items == (FW+1)'(1));
            r_o_frames <= 32'd0;
            r_o_delays <= 32'd0;
            r_o_status <= 3'd0;
            r_o_cut    <= 16'd0;
            if (r_data_en) begin
                r_o_byte <= r_data;
                r_o_kind <= rrd_pkg::KIND_REC;
            end else if (r_fill != '0) begin
                r_o_byte <= 8'd0;
                r_o_kind <= rrd_pkg::KIND_FILL;
            end else begin
                r_o_byte   <= 8'd0;
                r_o_kind   <= rrd_pkg::KIND_SUM;
                r_o_frames <= r_frames;
                r_o_delays <= r_delays;
                r_o_status <= r_status;
                r_o_cut    <= r_cut;
            end
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {5'd0, r_o_cut, r_o_status, r_o_delays, r_o_frames, r_o_byte};
    assign m_tlast  = r_o_last;
    assign m_tuser  = r_o_kind;

endmodule

### rtl/replay_record_deframer.sv
// Replay record deframer, top level.
// Instantiates the parser and the result emitter. Depends on rrd_pkg.
//
// Takes one file byte per cycle on the slave stream while s_tready is high and returns
// recorded bytes, filler zeros and one end summary on the master stream via the emitter's
// job and output registers. A byte with one result or none holds s_tready low only under
// backpressure. A byte with n results (an empty record gives players*4 filler words, the
// final byte adds the summary word) holds s_tready low until one result is left, as the
// emitter sends one word per cycle while not stalled. Downstream backpressure stalls the input too.
module replay_record_deframer #(
    parameter int MAX_PLAYERS = rrd_pkg::MAX_PLAYERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // in_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrd_pkg::TDATA_W-1:0]   m_tdata,  // out_byte, frame_total, delay_total,
                                                    // status, cut_bytes, zero pad
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser   // out_kind
);

    localparam int PW = $clog2(MAX_PLAYERS + 1);
    localparam int FW = PW + 2;

    rrd_pkg::t_job  job;
    logic [FW-1:0]  fill;
    logic           accept;

    assign accept = s_tvalid && s_tready;

    rrd_parse #(
        .MAX_PLAYERS (MAX_PLAYERS),
        .PW          (PW),
        .FW          (FW)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_job    (job),
        .o_fill   (fill)
    );

    rrd_emit #(
        .FW (FW)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_tvalid),
        .o_job_ready (s_tready),
        .i_job       (job),
        .i_fill      (fill),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/rrd_checker.sv
// Port-level checker for the replay record deframer, bound to the top level.
// Depends on rrd_pkg.
module rrd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rrd_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [1:0]                    m_tuser
);

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed under stall");

    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == rrd_pkg::KIND_SUM |-> m_tlast)
        else $error("summary word without tlast");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != rrd_pkg::KIND_SUM |-> m_tdata[rrd_pkg::TDATA_W-1:8] == '0)
        else $error("summary fields set on a data word");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == rrd_pkg::KIND_FILL |-> m_tdata[7:0] == 8'd0)
        else $error("filler word not zero");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == rrd_pkg::KIND_SUM |-> m_tdata[74:72] <= rrd_pkg::ST_NOFRAME)
        else $error("summary status out of range");

endmodule

bind replay_record_deframer rrd_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
